>>> src/extended_gcd_bezout_defines.svh
// Assertion helpers for the extended gcd block.
`ifndef EXTENDED_GCD_BEZOUT_DEFINES_SVH
`define EXTENDED_GCD_BEZOUT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EGCD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("egcd: implication check failed");

// Next-cycle implication, checked outside reset.
`define EGCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("egcd: next-cycle check failed");

`endif

>>> src/egcd_pkg.sv
package egcd_pkg;

	localparam int EGCD_WIDTH = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SETUP,
		ST_DIV,
		ST_UPDATE,
		ST_DONE
	} egcd_state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic div_step;
		logic update;
		logic out_load;
	} egcd_cmd_t;

	typedef struct packed {
		logic r1_zero;
		logic step_max;
		logic div_last;
	} egcd_sts_t;

endpackage

>>> src/extended_gcd_bezout.sv
// Extended gcd with Bezout coefficients: for signed operand_a and operand_b
// it returns gcd_value, coef_x and coef_y with a*x + b*y = g (mod 2^WIDTH),
// using truncating signed division, so gcd_value may be negative; b = 0
// gives g = a, x = 1, y = 0, and overflow flags a most-negative by -1 step.
// One request is processed at a time, over n Euclid steps (the step
// counter caps n at 2*WIDTH+2): each step runs a restoring divider that
// yields one quotient bit per cycle, with the coefficient products
// accumulated bit-serially alongside it. A finished result sits in an
// output register, so the next request is taken while it waits to be read.
`include "extended_gcd_bezout_defines.svh"

module extended_gcd_bezout
	import egcd_pkg::*;
#(
	parameter int WIDTH = EGCD_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [WIDTH-1:0] operand_a,
	input  logic signed [WIDTH-1:0] operand_b,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [WIDTH-1:0] gcd_value,
	output logic signed [WIDTH-1:0] coef_x,
	output logic signed [WIDTH-1:0] coef_y,
	output logic                    overflow
);

	egcd_cmd_t cmd;
	egcd_sts_t sts;
	logic [WIDTH-1:0] gcd_u, x_u, y_u;

	egcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	egcd_dp #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.a_in    ($unsigned(operand_a)),
		.b_in    ($unsigned(operand_b)),
		.gcd_out (gcd_u),
		.x_out   (x_u),
		.y_out   (y_u),
		.ovf_out (overflow)
	);

	assign gcd_value = $signed(gcd_u);
	assign coef_x = $signed(x_u);
	assign coef_y = $signed(y_u);

	`EGCD_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
	`EGCD_ASSERT_IMP(a_idle_on_result, $rose(out_valid), !in_stall)
	`EGCD_ASSERT_IMP(a_ovf_gcd, out_valid && overflow, gcd_value == '1)

endmodule

>>> src/egcd_ctrl.sv
module egcd_ctrl
	import egcd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  egcd_sts_t sts,
	output egcd_cmd_t cmd
);

	egcd_state_t state_q, state_nxt;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.r1_zero || sts.step_max) state_nxt = ST_DONE;
				else state_nxt = ST_SETUP;
			end
			ST_SETUP: begin
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_nxt = ST_CHECK;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			ST_DONE: begin
				cmd.out_load = !out_valid_q || !out_stall;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> src/egcd_dp.sv
module egcd_dp
	import egcd_pkg::*;
#(
	parameter int WIDTH = EGCD_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  egcd_cmd_t        cmd,
	output egcd_sts_t        sts,
	input  logic [WIDTH-1:0] a_in,
	input  logic [WIDTH-1:0] b_in,
	output logic [WIDTH-1:0] gcd_out,
	output logic [WIDTH-1:0] x_out,
	output logic [WIDTH-1:0] y_out,
	output logic             ovf_out
);

	localparam int STEP_MAX = 2 * WIDTH + 2;
	localparam int SW = $clog2(STEP_MAX + 1);
	localparam int BW = $clog2(WIDTH);

	logic [WIDTH-1:0] r0_q, r1_q, s0_q, s1_q, t0_q, t1_q;
	logic [WIDTH-1:0] dvd_q, dsr_q, rem_q, ps_q, pt_q;
	logic [WIDTH-1:0] gcd_q, x_q, y_q;
	logic             ovf_q, ovf_out_q, qneg_q, rneg_q;
	logic [BW-1:0]    bit_q;
	logic [SW-1:0]    step_q;

	logic [WIDTH-1:0] r0_mag, r1_mag, rem_nxt, r_signed, ns, nt;
	logic [WIDTH:0]   trial;
	logic             qbit;

	assign r0_mag = r0_q[WIDTH-1] ? (~r0_q + 1'b1) : r0_q;
	assign r1_mag = r1_q[WIDTH-1] ? (~r1_q + 1'b1) : r1_q;

	// restoring divide, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[WIDTH-1]} - {1'b0, dsr_q};
	assign qbit = !trial[WIDTH];
	assign rem_nxt = qbit ? trial[WIDTH-1:0] : {rem_q[WIDTH-2:0], dvd_q[WIDTH-1]};

	assign r_signed = rneg_q ? (~rem_q + 1'b1) : rem_q;
	assign ns = qneg_q ? (s0_q + ps_q) : (s0_q - ps_q);
	assign nt = qneg_q ? (t0_q + pt_q) : (t0_q - pt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			bit_q <= '0;
		end else begin
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.update) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.setup) begin
				bit_q <= BW'(WIDTH - 1);
			end else if (cmd.div_step) begin
				bit_q <= bit_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r0_q <= a_in;
			r1_q <= b_in;
			s0_q <= WIDTH'(1);
			s1_q <= '0;
			t0_q <= '0;
			t1_q <= WIDTH'(1);
			ovf_q <= 1'b0;
		end else if (cmd.update) begin
			r0_q <= r1_q;
			r1_q <= r_signed;
			s0_q <= s1_q;
			s1_q <= ns;
			t0_q <= t1_q;
			t1_q <= nt;
		end else if (cmd.setup) begin
			if (r0_q == {1'b1, {(WIDTH-1){1'b0}}} && r1_q == '1) ovf_q <= 1'b1;
		end

		if (cmd.setup) begin
			dvd_q <= r0_mag;
			dsr_q <= r1_mag;
			rem_q <= '0;
			ps_q <= '0;
			pt_q <= '0;
			qneg_q <= r0_q[WIDTH-1] ^ r1_q[WIDTH-1];
			rneg_q <= r0_q[WIDTH-1];
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
			rem_q <= rem_nxt;
			// quotient times coefficient, built MSB first alongside the divide
			ps_q <= {ps_q[WIDTH-2:0], 1'b0} + (qbit ? s1_q : '0);
			pt_q <= {pt_q[WIDTH-2:0], 1'b0} + (qbit ? t1_q : '0);
		end

		if (cmd.out_load) begin
			gcd_q <= r0_q;
			x_q <= s0_q;
			y_q <= t0_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign sts.r1_zero = (r1_q == '0);
	assign sts.step_max = (step_q == SW'(STEP_MAX));
	assign sts.div_last = (bit_q == '0);

	assign gcd_out = gcd_q;
	assign x_out = x_q;
	assign y_out = y_q;
	assign ovf_out = ovf_out_q;

endmodule

>>> tb/sv/extended_gcd_bezout_tb.sv
module extended_gcd_bezout_tb;
	import egcd_pkg::*;

	localparam int W = EGCD_WIDTH;
	localparam logic [W-1:0] NEG_MAX = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] POS_MAX = ~NEG_MAX;
	localparam int RAND_REQS = 400;
	localparam int PHASE_A_END = 150;
	localparam int PHASE_B_END = 300;
	localparam int HOLD_CYCLES = 4000;
	localparam int HOLD_AFTER = 40;
	localparam int QUIET_LIMIT = 20000;
	localparam int TAIL_CYCLES = 60;
	localparam int MAX_PRINTED = 40;

	typedef struct {
		logic [W-1:0] a;
		logic [W-1:0] b;
		bit           drain;
	} gcd_req_t;

	typedef struct packed {
		logic [W-1:0] gcd;
		logic [W-1:0] x;
		logic [W-1:0] y;
		logic         ovf;
	} bezout_t;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [W-1:0]     operand_a = '0;
	logic signed [W-1:0]     operand_b = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [W-1:0]     gcd_value;
	logic signed [W-1:0]     coef_x;
	logic signed [W-1:0]     coef_y;
	logic                    overflow;

	gcd_req_t pending_reqs[$];
	bezout_t  expected_bezout[$];
	int       queued_cnt = 0;
	int       reqs_sent = 0;
	int       results_seen = 0;
	int       quiet_cycles = 0;
	int       err_cnt = 0;
	int       hold_left = 0;
	bit       hold_used = 1'b0;

	extended_gcd_bezout #(
		.WIDTH(W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.gcd_value(gcd_value),
		.coef_x   (coef_x),
		.coef_y   (coef_y),
		.overflow (overflow)
	);

	// Euclid with truncating division, everything wrapping at W bits.
	function automatic bezout_t bezout_of(logic [W-1:0] a, logic [W-1:0] b);
		logic [W-1:0] r0, r1, s0, s1, t0, t1;
		logic [W-1:0] mag_n, mag_d, uq, ur, q, r, ns, nt;
		bezout_t res;
		int n;
		r0 = a;
		r1 = b;
		s0 = 1;
		s1 = 0;
		t0 = 0;
		t1 = 1;
		res.ovf = 1'b0;
		for (n = 0; n < 2 * W + 2 && r1 != 0; n++) begin
			if (r0 == NEG_MAX && r1 == '1)
				res.ovf = 1'b1;
			mag_n = r0[W-1] ? -r0 : r0;
			mag_d = r1[W-1] ? -r1 : r1;
			uq = mag_n / mag_d;
			ur = mag_n % mag_d;
			q = (r0[W-1] != r1[W-1]) ? -uq : uq;
			r = r0[W-1] ? -ur : ur;
			ns = s0 - q * s1;
			nt = t0 - q * t1;
			r0 = r1;
			r1 = r;
			s0 = s1;
			s1 = ns;
			t0 = t1;
			t1 = nt;
		end
		res.gcd = r0;
		res.x = s0;
		res.y = t0;
		return res;
	endfunction

	task automatic report_err(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_PRINTED)
			$display("mismatch: %s", msg);
	endtask

	task automatic add_req(input logic [W-1:0] a, input logic [W-1:0] b);
		gcd_req_t r;
		r.a = a;
		r.b = b;
		r.drain = (queued_cnt == PHASE_A_END) || (queued_cnt == PHASE_B_END);
		pending_reqs.push_back(r);
		queued_cnt++;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// request driver
	always @(posedge clk) begin : drive_reqs
		gcd_req_t nxt;
		int idle_pct;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				reqs_sent++;
			idle_pct = (reqs_sent < PHASE_A_END) ? 18 : (reqs_sent < PHASE_B_END) ? 48 : 0;
			if (pending_reqs.size() != 0
			    && !(pending_reqs[0].drain && results_seen != reqs_sent)
			    && $urandom_range(99) >= idle_pct) begin
				nxt = pending_reqs.pop_front();
				in_valid <= 1'b1;
				operand_a <= nxt.a;
				operand_b <= nxt.b;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side stall, with one long hold-off
	always @(posedge clk) begin : drive_stall
		int idle_pct;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (!hold_used && results_seen >= HOLD_AFTER) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			idle_pct = (results_seen < PHASE_A_END) ? 48 : (results_seen < PHASE_B_END) ? 18 : 0;
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// monitor: predicts on each request, checks each result
	always @(posedge clk) begin : watch_ports
		bezout_t want;
		bit busy;
		if (arst_n) begin
			busy = 1'b0;
			if (out_valid && !out_stall) begin
				busy = 1'b1;
				if (expected_bezout.size() == 0) begin
					report_err($sformatf("result gcd %0d with no request pending", gcd_value));
				end else begin
					want = expected_bezout.pop_front();
					if (gcd_value !== want.gcd)
						report_err($sformatf("result %0d gcd_value %0d, predicted %0d",
							results_seen, gcd_value, $signed(want.gcd)));
					if (coef_x !== want.x)
						report_err($sformatf("result %0d coef_x %0d, predicted %0d",
							results_seen, coef_x, $signed(want.x)));
					if (coef_y !== want.y)
						report_err($sformatf("result %0d coef_y %0d, predicted %0d",
							results_seen, coef_y, $signed(want.y)));
					if (overflow !== want.ovf)
						report_err($sformatf("result %0d overflow %b, predicted %b",
							results_seen, overflow, want.ovf));
					results_seen++;
				end
			end
			if (in_valid && !in_stall) begin
				busy = 1'b1;
				expected_bezout.push_back(bezout_of(operand_a, operand_b));
			end
			quiet_cycles = busy ? 0 : quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (arst_n);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [W-1:0] corner_vals[5];
		logic [W-1:0] a, b, g, f0, f1, f2;
		int n, k, kind;

		corner_vals[0] = NEG_MAX;
		corner_vals[1] = POS_MAX;
		corner_vals[2] = '1;
		corner_vals[3] = '0;
		corner_vals[4] = 1;

		// directed
		add_req(0, 0);
		add_req(5, 0);
		add_req(-5, 0);
		add_req(0, 7);
		add_req(NEG_MAX, 0);
		add_req(NEG_MAX, '1);
		add_req('1, NEG_MAX);
		add_req(NEG_MAX, NEG_MAX);
		add_req(POS_MAX, NEG_MAX);
		add_req(NEG_MAX, POS_MAX);
		add_req(POS_MAX, POS_MAX);
		add_req(POS_MAX, 1);
		add_req('1, '1);
		add_req(1, '1);
		add_req(240, 46);
		add_req(-240, 46);
		add_req(240, -46);
		add_req(-240, -46);
		add_req(46, 240);
		add_req(1836311903, 1134903170);
		add_req(-1836311903, 1134903170);
		add_req(NEG_MAX, 2);
		add_req(12, NEG_MAX);

		for (n = 0; n < RAND_REQS; n++) begin
			kind = $urandom_range(9);
			a = $urandom;
			b = $urandom;
			case (kind)
				4, 5: begin
					g = $urandom_range(4000, 1);
					a = g * $urandom_range(400000, 0);
					b = g * $urandom_range(400000, 0);
					if ($urandom_range(1)) a = -a;
					if ($urandom_range(1)) b = -b;
				end
				6: begin
					a = $urandom_range(128) - 64;
					b = $urandom_range(128) - 64;
				end
				7: begin
					a = corner_vals[$urandom_range(4)];
					if ($urandom_range(1)) b = corner_vals[$urandom_range(4)];
				end
				8: begin
					if ($urandom_range(1)) b = 0;
					else a = 0;
				end
				9: begin
					f0 = 0;
					f1 = 1;
					k = $urandom_range(46, 20);
					repeat (k) begin
						f2 = f0 + f1;
						f0 = f1;
						f1 = f2;
					end
					a = f1;
					b = f0;
					if ($urandom_range(1)) a = -a;
					if ($urandom_range(1)) b = -b;
				end
				default: ;
			endcase
			add_req(a, b);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || in_valid || expected_bezout.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_bezout.size() != 0)
			report_err($sformatf("%0d results never came", expected_bezout.size()));

		if (err_cnt == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
